>>> rtl/core/frcs_pkg.sv
// Shared types and constants of the file read cluster splitter.
package frcs_pkg;

   localparam int MAP_ENTRIES = 11;
   localparam int MAP_IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int MAX_REQUEST = 32256;

   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH  = 4;
   localparam int RSPQ_PTR_W  = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W  = $clog2(RSPQ_DEPTH + 1);

   localparam int CSIZE_W     = 20;
   localparam int DIV_CNT_W   = 5;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_SEEK = 2'd2;

   typedef enum logic [1:0] {
      CSR_SECTOR_BYTES        = 2'd0,
      CSR_SECTORS_PER_CLUSTER = 2'd1,
      CSR_DATA_FIRST_SECTOR   = 2'd2,
      CSR_FILE_SIZE           = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_READ,
      OP_SEEK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  map_index;
      logic [27:0] disk_cluster;
      logic [14:0] request_bytes;
      logic [31:0] new_position;
   } cmd_type;

   typedef struct packed {
      logic [31:0] start_sector;
      logic [18:0] byte_offset;
      logic [14:0] chunk_bytes;
      logic        bad_cluster;
      logic [14:0] total_read;
      logic        at_end;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_START,
      S_DIV_WAIT,
      S_STEP,
      S_EMIT,
      S_EMPTY
   } back_state_type;

endpackage

>>> rtl/core/frcs_front.sv
// Front end: decodes and clamps requests and queues them for the back end.
module frcs_front
   import frcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_map_index,
   input  logic [27:0] req_disk_cluster,
   input  logic [14:0] req_request_bytes,
   input  logic [31:0] req_new_position,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type                 queue_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   cmd_type                 decoded;
   logic                    do_push;
   logic                    do_pop;

   always_comb begin
      decoded.map_index     = req_map_index;
      decoded.disk_cluster  = req_disk_cluster;
      decoded.new_position  = req_new_position;
      decoded.request_bytes = (req_request_bytes > 15'(MAX_REQUEST)) ?
                              15'(MAX_REQUEST) : req_request_bytes;
      case (req_mode)
         MODE_LOAD: decoded.op = OP_LOAD;
         MODE_READ: decoded.op = OP_READ;
         MODE_SEEK: decoded.op = OP_SEEK;
         default:   decoded.op = OP_NONE;
      endcase
   end

   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/core/frcs_div.sv
// Radix-2 restoring divider: file position by cluster size.
module frcs_div
   import frcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        dividend,
   input  logic [CSIZE_W-1:0] divisor,
   output logic               done,
   output logic [31:0]        quotient,
   output logic [CSIZE_W-1:0] remainder
);

   logic [31:0]          quo_ff, quo_in;
   logic [CSIZE_W-1:0]   rem_ff, rem_in;
   logic [CSIZE_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CSIZE_W:0]     trial;

   assign trial = {rem_ff, quo_ff[31]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CSIZE_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[CSIZE_W-1:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/frcs_rsp_fifo.sv
// Result queue between the back end and the rsp_ ports.
module frcs_rsp_fifo
   import frcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type pop_data
);

   rsp_type                 queue_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full     = (count_ff == RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = queue_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSPQ_CNT_W'(RSPQ_DEPTH))
      else $error("result queue count past depth");

   a_pop_moves_ptr: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("result queue pop lost");

endmodule

>>> rtl/core/frcs_back.sv
// Back end: config registers, cluster map, file position and the cluster walk.
module frcs_back
   import frcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_push,
   output rsp_type     rsp,
   input  logic        rsp_full
);

   back_state_type     state_ff, state_in;
   logic [12:0]        sb_ff;
   logic [7:0]         spc_ff;
   logic [31:0]        dfs_ff;
   logic [31:0]        fsize_ff;
   logic [27:0]        map_ff [MAP_ENTRIES];

   logic [31:0]        pos_ff, pos_in;
   logic [14:0]        left_ff, left_in;
   logic [31:0]        start_ff, start_in;
   logic [CSIZE_W-1:0] csize_ff, csize_in;
   logic [31:0]        clu_ff, clu_in;
   logic [CSIZE_W-1:0] off_ff, off_in;
   logic [14:0]        valid_ff, valid_in;
   logic [31:0]        prod_ff, prod_in;
   logic               bad_ff, bad_in;

   logic [12:0]        sb_eff;
   logic [7:0]         spc_eff;
   logic               map_we;
   logic               div_start;
   logic               div_done;
   logic [31:0]        div_quo;
   logic [CSIZE_W-1:0] div_rem;
   logic [27:0]        map_rd;
   logic [31:0]        room;
   logic [31:0]        tail;
   logic [31:0]        step;
   logic [31:0]        pos_next;
   logic [14:0]        left_next;
   logic               fin;

   assign sb_eff  = (sb_ff < 13'd512) ? 13'd512 : ((sb_ff > 13'd4096) ? 13'd4096 : sb_ff);
   assign spc_eff = (spc_ff == 8'd0) ? 8'd1 : ((spc_ff > 8'd128) ? 8'd128 : spc_ff);
   assign map_rd  = map_ff[MAP_IDX_W'(clu_ff)];

   frcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (pos_ff),
      .divisor   (csize_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      room      = 32'(csize_ff) - 32'(off_ff);
      tail      = fsize_ff - pos_ff;
      step      = (room < tail) ? room : tail;
      if (32'(left_ff) < step) begin
         step = 32'(left_ff);
      end
      pos_next  = pos_ff + 32'(valid_ff);
      left_next = left_ff - valid_ff;
      fin       = (left_next == '0) || (pos_next >= fsize_ff);
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      start_in  = start_ff;
      csize_in  = csize_ff;
      clu_in    = clu_ff;
      off_in    = off_ff;
      valid_in  = valid_ff;
      prod_in   = prod_ff;
      bad_in    = bad_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp       = '0;
      div_start = 1'b0;
      map_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = S_EMPTY;
               case (cmd.op)
                  OP_LOAD: begin
                     map_we = (32'(cmd.map_index) < 32'(MAP_ENTRIES));
                  end
                  OP_SEEK: begin
                     pos_in = cmd.new_position;
                  end
                  OP_READ: begin
                     left_in  = cmd.request_bytes;
                     start_in = pos_ff;
                     csize_in = CSIZE_W'(sb_eff) * CSIZE_W'(spc_eff);
                     if ((cmd.request_bytes != '0) && (pos_ff < fsize_ff)) begin
                        state_in = S_DIV_START;
                     end
                  end
                  default: begin
                     state_in = S_EMPTY;
                  end
               endcase
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               clu_in   = div_quo;
               off_in   = div_rem;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            valid_in = 15'(step);
            bad_in   = (clu_ff >= 32'(MAP_ENTRIES));
            prod_in  = 32'((32'(map_rd) - 32'd2) * 32'(spc_eff));
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push         = 1'b1;
               rsp.start_sector = bad_ff ? '0 : prod_ff + dfs_ff;
               rsp.byte_offset  = 19'(off_ff);
               rsp.chunk_bytes  = bad_ff ? '0 : valid_ff;
               rsp.bad_cluster  = bad_ff;
               rsp.total_read   = fin ? 15'(pos_next - start_ff) : '0;
               rsp.at_end       = (pos_next >= fsize_ff);
               rsp.last         = fin;
               pos_in           = pos_next;
               left_in          = left_next;
               if (fin) begin
                  state_in = S_IDLE;
               end else begin
                  clu_in   = clu_ff + 32'd1;
                  off_in   = '0;
                  state_in = S_STEP;
               end
            end
         end
         S_EMPTY: begin
            if (!rsp_full) begin
               rsp_push   = 1'b1;
               rsp.at_end = (pos_ff >= fsize_ff);
               rsp.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         sb_ff    <= 13'd512;
         spc_ff   <= 8'd1;
         dfs_ff   <= '0;
         fsize_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_SECTOR_BYTES:        sb_ff    <= csr_wdata[12:0];
               CSR_SECTORS_PER_CLUSTER: spc_ff   <= csr_wdata[7:0];
               CSR_DATA_FIRST_SECTOR:   dfs_ff   <= csr_wdata;
               CSR_FILE_SIZE:           fsize_ff <= csr_wdata;
               default:                 sb_ff    <= sb_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_ENTRIES; i++) begin
            map_ff[i] <= '0;
         end
      end else if (map_we) begin
         map_ff[MAP_IDX_W'(cmd.map_index)] <= cmd.disk_cluster;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      start_ff <= start_in;
      csize_ff <= csize_in;
      clu_ff   <= clu_in;
      off_ff   <= off_in;
      valid_ff <= valid_in;
      prod_ff  <= prod_in;
      bad_ff   <= bad_in;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_offset_in_cluster: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (off_ff < csize_ff))
      else $error("offset not inside cluster");

   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp.last) |=> (state_ff == S_STEP && off_ff == '0))
      else $error("cluster walk did not continue at boundary");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE && cmd_valid))
      else $error("request taken while busy");

endmodule

>>> rtl/core/file_read_cluster_splitter_top.sv
// Top level of the file read cluster splitter.
//
// Requests enter through a queue interface (req_push / req_full) and results
// leave through another (rsp_empty / rsp_pop); each request gives one or more
// results, the final one flagged by rsp_last. Mode 0 loads a cluster map entry,
// mode 1 reads from the current file position, mode 2 sets the position;
// everything but a read that moves data gives one empty result.
// Registers are written through csr_we / csr_index / csr_wdata; the user must
// write them only while idle; nothing in the block itself enforces this.
// A two-entry request queue lets a new request in while the back end works.
// Map loads and seeks go through the empty-result state to the result queue.
// A read first divides the position by the cluster size in a radix-2
// divider; each cluster then takes a map lookup and sector multiply, then an
// emit. A read gives up to 64 commands.
// A four-entry result queue decouples the back end from rsp_pop; when it is
// full the walk stalls and no results are dropped.
// Synchronous reset empties both queues, sets position 0, clears the map and
// restores the register reset values.
module file_read_cluster_splitter_top
   import frcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_map_index,
   input  logic [27:0] req_disk_cluster,
   input  logic [14:0] req_request_bytes,
   input  logic [31:0] req_new_position,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_start_sector,
   output logic [18:0] rsp_byte_offset,
   output logic [14:0] rsp_chunk_bytes,
   output logic        rsp_bad_cluster,
   output logic [14:0] rsp_total_read,
   output logic        rsp_at_end,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    push;
   rsp_type push_data;
   logic    full;
   rsp_type head;

   frcs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_map_index     (req_map_index),
      .req_disk_cluster  (req_disk_cluster),
      .req_request_bytes (req_request_bytes),
      .req_new_position  (req_new_position),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   frcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (push),
      .rsp       (push_data),
      .rsp_full  (full)
   );

   frcs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (head)
   );

   assign rsp_start_sector = head.start_sector;
   assign rsp_byte_offset  = head.byte_offset;
   assign rsp_chunk_bytes  = head.chunk_bytes;
   assign rsp_bad_cluster  = head.bad_cluster;
   assign rsp_total_read   = head.total_read;
   assign rsp_at_end       = head.at_end;
   assign rsp_last         = head.last;

endmodule
